// ===== design/est_pkg.sv =====
package est_pkg;

   typedef enum logic [1:0] {
      CMD_SUBSCRIBE   = 2'd0,
      CMD_UNSUBSCRIBE = 2'd1,
      CMD_COUNT       = 2'd2,
      CMD_PUBLISH     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_INVALID  = 2'd1,
      STS_DUP_MISS = 2'd2,
      STS_FULL     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_TAIL,
      S_EMIT,
      S_DONE
   } state_type;

   localparam logic [1:0] CSR_FIRST_USER   = 2'd0;
   localparam logic [1:0] CSR_SIGNALS_USED = 2'd1;
   localparam logic [1:0] CSR_SLOTS_USED   = 2'd2;

   localparam logic [4:0] FIRST_USER_RESET   = 5'd4;
   localparam logic [5:0] SIGNALS_USED_RESET = 6'd32;
   localparam logic [3:0] SLOTS_USED_RESET   = 4'd8;

   typedef struct packed {
      logic [4:0] first_user_signal;
      logic [5:0] signals_in_use;
      logic [3:0] slots_per_signal;
   } est_cfg_type;

   typedef struct packed {
      logic       load;
      status_type status;
      logic       has_subscriber;
      logic [7:0] subscriber_out;
      logic [3:0] count;
      logic       last;
   } est_rsp_type;

endpackage

// ===== design/est_ram.sv =====
module est_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/est_ctrl.sv =====
module est_ctrl
   import est_pkg::*;
#(
   parameter int MAX_SIGNALS = 32,
   parameter int MAX_SLOTS = 8,
   parameter int ID_BITS = 8,
   localparam int AW = $clog2(MAX_SIGNALS * MAX_SLOTS)
) (
   input  logic               clock,
   input  logic               reset,
   input  est_cfg_type        cfg,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [4:0]         req_signal,
   input  logic [7:0]         req_subscriber_id,
   input  logic               out_free,
   output est_rsp_type        rsp_load,
   output logic               ram_wr_en,
   output logic [AW-1:0]      ram_wr_addr,
   output logic [ID_BITS-1:0] ram_wr_data,
   output logic [AW-1:0]      ram_rd_addr,
   input  logic [ID_BITS-1:0] ram_rd_data
);

   localparam int DEPTH = MAX_SIGNALS * MAX_SLOTS;
   localparam int SW = $clog2(MAX_SLOTS + 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   state_type          state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   cmd_type            cmd_ff, cmd_in;
   logic [AW-1:0]      base_ff, base_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   logic [SW-1:0]      n_ff, n_in;
   logic [SW-1:0]      idx_ff, idx_in;
   logic [SW-1:0]      pidx_ff, pidx_in;
   logic               pend_ff, pend_in;
   logic               hit_ff, hit_in;
   logic               emp_ff, emp_in;
   logic [SW-1:0]      eidx_ff, eidx_in;
   logic [SW-1:0]      total_ff, total_in;
   logic [SW-1:0]      k_ff, k_in;
   status_type         status_ff, status_in;
   logic [SW-1:0]      cnt_ff, cnt_in;

   logic [ID_BITS+7:0] req_id_ext;
   logic [ID_BITS-1:0] req_id;
   logic [SW-1:0]      n_act;
   logic               sig_bad;
   logic               id_bad;
   logic [AW-1:0]      req_base;
   logic               d_nz;
   logic               d_hit;
   logic               last_slot;
   logic               hold;
   logic [ID_BITS+7:0] d_ext;
   logic [SW+3:0]      total_ext;
   logic [SW+3:0]      cnt_ext;

   assign req_id_ext = {{ID_BITS{1'b0}}, req_subscriber_id};
   assign req_id     = req_id_ext[ID_BITS-1:0];
   assign req_base   = AW'(32'(req_signal) * MAX_SLOTS);

   always_comb begin
      if (cfg.slots_per_signal == 4'd0) begin
         n_act = SW'(1);
      end else if (32'(cfg.slots_per_signal) > MAX_SLOTS) begin
         n_act = SW'(MAX_SLOTS);
      end else begin
         n_act = SW'(cfg.slots_per_signal);
      end
   end

   // count ignores the user base
   assign sig_bad = (32'(req_signal) >= MAX_SIGNALS) ||
                    ({1'b0, req_signal} >= cfg.signals_in_use) ||
                    ((req_cmd != CMD_COUNT) && (req_signal < cfg.first_user_signal));
   assign id_bad  = ((req_cmd == CMD_SUBSCRIBE) || (req_cmd == CMD_UNSUBSCRIBE)) &&
                    (req_id == '0);

   assign d_nz      = ram_rd_data != '0;
   assign d_hit     = ram_rd_data == id_ff;
   assign last_slot = pidx_ff == (n_ff - SW'(1));
   assign hold      = pend_ff && d_nz && !out_free;
   assign d_ext     = {8'b0, ram_rd_data};
   assign total_ext = {4'b0, total_ff};
   assign cnt_ext   = {4'b0, cnt_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      cmd_ff    <= cmd_in;
      base_ff   <= base_in;
      id_ff     <= id_in;
      n_ff      <= n_in;
      idx_ff    <= idx_in;
      pidx_ff   <= pidx_in;
      pend_ff   <= pend_in;
      hit_ff    <= hit_in;
      emp_ff    <= emp_in;
      eidx_ff   <= eidx_in;
      total_ff  <= total_in;
      k_ff      <= k_in;
      status_ff <= status_in;
      cnt_ff    <= cnt_in;
   end

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      cmd_in      = cmd_ff;
      base_in     = base_ff;
      id_in       = id_ff;
      n_in        = n_ff;
      idx_in      = idx_ff;
      pidx_in     = pidx_ff;
      pend_in     = pend_ff;
      hit_in      = hit_ff;
      emp_in      = emp_ff;
      eidx_in     = eidx_ff;
      total_in    = total_ff;
      k_in        = k_ff;
      status_in   = status_ff;
      cnt_in      = cnt_ff;
      req_stall   = 1'b1;
      rsp_load    = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = base_ff;
      ram_wr_data = '0;
      ram_rd_addr = base_ff + AW'(idx_ff);

      unique case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            clr_in      = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd_in   = cmd_type'(req_cmd);
               base_in  = req_base;
               id_in    = req_id;
               n_in     = n_act;
               idx_in   = '0;
               pend_in  = 1'b0;
               hit_in   = 1'b0;
               emp_in   = 1'b0;
               eidx_in  = '0;
               total_in = '0;
               k_in     = '0;
               cnt_in   = '0;
               if (sig_bad || id_bad) begin
                  status_in = STS_INVALID;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            // one slot read issued per cycle, its data evaluated the next
            pend_in = idx_ff < n_ff;
            pidx_in = idx_ff;
            if (idx_ff < n_ff) begin
               idx_in = idx_ff + SW'(1);
            end
            if (pend_ff) begin
               unique case (cmd_ff)
                  CMD_SUBSCRIBE: begin
                     if (d_hit) begin
                        hit_in = 1'b1;
                     end
                     if (!d_nz && !emp_ff) begin
                        emp_in  = 1'b1;
                        eidx_in = pidx_ff;
                     end
                  end
                  CMD_UNSUBSCRIBE: begin
                     // once the id is found every later slot moves down by one
                     if (hit_ff) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = base_ff + AW'(pidx_ff) - AW'(1);
                        ram_wr_data = ram_rd_data;
                     end else if (d_hit) begin
                        hit_in = 1'b1;
                     end
                  end
                  CMD_COUNT, CMD_PUBLISH: begin
                     if (d_nz) begin
                        total_in = total_ff + SW'(1);
                     end
                  end
               endcase
               if (last_slot) begin
                  unique case (cmd_ff)
                     CMD_SUBSCRIBE: begin
                        state_in = S_DONE;
                        if (hit_in) begin
                           status_in = STS_DUP_MISS;
                        end else if (emp_in) begin
                           ram_wr_en   = 1'b1;
                           ram_wr_addr = base_ff + AW'(eidx_in);
                           ram_wr_data = id_ff;
                           status_in   = STS_OK;
                        end else begin
                           status_in = STS_FULL;
                        end
                     end
                     CMD_UNSUBSCRIBE: begin
                        if (hit_in) begin
                           state_in = S_TAIL;
                        end else begin
                           status_in = STS_DUP_MISS;
                           state_in  = S_DONE;
                        end
                     end
                     CMD_COUNT: begin
                        status_in = STS_OK;
                        cnt_in    = total_in;
                        state_in  = S_DONE;
                     end
                     CMD_PUBLISH: begin
                        if (total_in == '0) begin
                           status_in = STS_OK;
                           cnt_in    = '0;
                           state_in  = S_DONE;
                        end else begin
                           idx_in   = '0;
                           pend_in  = 1'b0;
                           state_in = S_EMIT;
                        end
                     end
                  endcase
               end
            end
         end

         S_TAIL: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = base_ff + AW'(n_ff) - AW'(1);
            status_in   = STS_OK;
            state_in    = S_DONE;
         end

         S_EMIT: begin
            // while the output is blocked the pending slot is read again
            if (hold) begin
               ram_rd_addr = base_ff + AW'(pidx_ff);
            end else begin
               pend_in = idx_ff < n_ff;
               pidx_in = idx_ff;
               if (idx_ff < n_ff) begin
                  idx_in = idx_ff + SW'(1);
               end
            end
            if (pend_ff && d_nz && out_free) begin
               rsp_load.load           = 1'b1;
               rsp_load.status         = STS_OK;
               rsp_load.has_subscriber = 1'b1;
               rsp_load.subscriber_out = d_ext[7:0];
               rsp_load.count          = total_ext[3:0];
               rsp_load.last           = (k_ff + SW'(1)) == total_ff;
               k_in                    = k_ff + SW'(1);
               if (rsp_load.last) begin
                  state_in = S_IDLE;
               end
            end
         end

         S_DONE: begin
            if (out_free) begin
               rsp_load.load   = 1'b1;
               rsp_load.status = status_ff;
               rsp_load.count  = cnt_ext[3:0];
               rsp_load.last   = 1'b1;
               state_in        = S_IDLE;
            end
         end
      endcase
   end

endmodule

// ===== design/event_subscription_table_unit.sv =====
// channel | dir | ports                                        | transfer when
// req     | in  | req_valid req_stall req_cmd req_signal        | req_valid && !req_stall
//         |     | req_subscriber_id                            |
// rsp     | out | rsp_valid rsp_stall rsp_status                | rsp_valid && !rsp_stall
//         |     | rsp_has_subscriber rsp_subscriber_out        |
//         |     | rsp_count rsp_last                           |
// csr     | in  | csr_wr_en csr_index csr_wdata                 | csr_wr_en
//
// every command but a rejected one scans the row of n active slots; an unsubscribe that
// removes an id then clears the last slot. the slot RAM gives one read per cycle, so the row
// scan sets the pace. publish runs a counting scan, then, if the row holds any id, an
// emitting scan; every command is held up while the result side stalls.
// after reset the slot RAM is cleared one entry a cycle, all MAX_SIGNALS * MAX_SLOTS entries,
// with req_stall high; csr writes are taken throughout.
module event_subscription_table_unit
   import est_pkg::*;
#(
   parameter int MAX_SIGNALS = 32,
   parameter int MAX_SLOTS = 8,
   parameter int ID_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_cmd,
   input  logic [4:0] req_signal,
   input  logic [7:0] req_subscriber_id,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic       rsp_has_subscriber,
   output logic [7:0] rsp_subscriber_out,
   output logic [3:0] rsp_count,
   output logic       rsp_last,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [5:0] csr_wdata
);

   localparam int DEPTH = MAX_SIGNALS * MAX_SLOTS;
   localparam int AW = $clog2(DEPTH);

   logic [4:0]   first_ff, first_in;
   logic [5:0]   sigs_ff, sigs_in;
   logic [3:0]   slots_ff, slots_in;
   logic         rsp_valid_ff, rsp_valid_in;
   status_type   rsp_status_ff, rsp_status_in;
   logic         rsp_has_ff, rsp_has_in;
   logic [7:0]   rsp_id_ff, rsp_id_in;
   logic [3:0]   rsp_count_ff, rsp_count_in;
   logic         rsp_last_ff, rsp_last_in;

   est_cfg_type        cfg;
   est_rsp_type        rsp_load;
   logic               out_free;
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [ID_BITS-1:0] ram_wr_data;
   logic [AW-1:0]      ram_rd_addr;
   logic [ID_BITS-1:0] ram_rd_data;

   always_comb begin
      first_in = first_ff;
      sigs_in  = sigs_ff;
      slots_in = slots_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FIRST_USER:   first_in = csr_wdata[4:0];
            CSR_SIGNALS_USED: sigs_in  = csr_wdata;
            CSR_SLOTS_USED:   slots_in = csr_wdata[3:0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= FIRST_USER_RESET;
         sigs_ff  <= SIGNALS_USED_RESET;
         slots_ff <= SLOTS_USED_RESET;
      end else begin
         first_ff <= first_in;
         sigs_ff  <= sigs_in;
         slots_ff <= slots_in;
      end
   end

   assign cfg.first_user_signal = first_ff;
   assign cfg.signals_in_use    = sigs_ff;
   assign cfg.slots_per_signal  = slots_ff;

   // output register parts the result side from the sequencer
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      if (rsp_load.load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = rsp_load.status;
         rsp_has_in    = rsp_load.has_subscriber;
         rsp_id_in     = rsp_load.subscriber_out;
         rsp_count_in  = rsp_load.count;
         rsp_last_in   = rsp_load.last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_has_subscriber = rsp_has_ff;
   assign rsp_subscriber_out = rsp_id_ff;
   assign rsp_count          = rsp_count_ff;
   assign rsp_last           = rsp_last_ff;

   est_ctrl #(
      .MAX_SIGNALS(MAX_SIGNALS),
      .MAX_SLOTS  (MAX_SLOTS),
      .ID_BITS    (ID_BITS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_signal       (req_signal),
      .req_subscriber_id(req_subscriber_id),
      .out_free         (out_free),
      .rsp_load         (rsp_load),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data)
   );

   est_ram #(
      .WIDTH(ID_BITS),
      .DEPTH(DEPTH)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

endmodule

// ===== design/est_checker.sv =====
module est_checker
   import est_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_status,
   input logic       rsp_has_subscriber,
   input logic [7:0] rsp_subscriber_out,
   input logic [3:0] rsp_count,
   input logic       rsp_last
);

   // a stalled result transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_has_subscriber) && $stable(rsp_subscriber_out) &&
      $stable(rsp_count) && $stable(rsp_last))
      else $error("result changed while stalled");

   // only publish gives more than one result per item
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_subscriber |-> rsp_last)
      else $error("non-publish result without last");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STS_OK) |->
      !rsp_has_subscriber && (rsp_subscriber_out == 8'd0) && (rsp_count == 4'd0))
      else $error("error result carries data");

   // slot memory is being cleared right after reset
   a_clear_stall: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> req_stall)
      else $error("request taken during clearing pass");

endmodule

bind event_subscription_table_unit est_checker u_est_checker (.*);

// ===== sim/event_subscription_table_unit_test.sv =====
module event_subscription_table_unit_test;
   import est_pkg::*;

   localparam int HOLD_OFF_CYCLES = 240;

   typedef struct {
      status_type status;
      logic       has_subscriber;
      logic [7:0] subscriber_out;
      logic [3:0] count;
      logic       last;
   } delivery_type;

   class subscription_tracker_type;
      logic [7:0]   subscriber_rows [32][8];
      logic [4:0]   first_user;
      logic [5:0]   signals_used;
      logic [3:0]   slots_used;
      delivery_type pending_deliveries [$];
      int           mismatches;
      int           checked;

      function new();
         foreach (subscriber_rows[r, s]) subscriber_rows[r][s] = 8'h00;
         first_user   = FIRST_USER_RESET;
         signals_used = SIGNALS_USED_RESET;
         slots_used   = SLOTS_USED_RESET;
         mismatches   = 0;
         checked      = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [5:0] value);
         case (idx)
            CSR_FIRST_USER: first_user = value[4:0];
            CSR_SIGNALS_USED: signals_used = value;
            CSR_SLOTS_USED: slots_used = value[3:0];
            default: ;
         endcase
      endfunction

      // works out the deliveries one accepted request causes and updates the rows
      function void note_request(cmd_type cmd, logic [4:0] sig, logic [7:0] id);
         int n;
         int rows;
         int pos;
         int total;
         int k;
         delivery_type d;
         n = (slots_used == 0) ? 1 : ((slots_used > 8) ? 8 : slots_used);
         rows = (signals_used > 32) ? 32 : signals_used;
         d = '{STS_OK, 1'b0, 8'h00, 4'd0, 1'b1};
         if (sig >= rows || (cmd != CMD_COUNT && sig < first_user) ||
             ((cmd == CMD_SUBSCRIBE || cmd == CMD_UNSUBSCRIBE) && id == 8'h00)) begin
            d.status = STS_INVALID;
            pending_deliveries.push_back(d);
            return;
         end
         case (cmd)
            CMD_SUBSCRIBE, CMD_UNSUBSCRIBE: begin
               pos = n;
               for (int i = n - 1; i >= 0; i--) begin
                  if (subscriber_rows[sig][i] == id) pos = i;
               end
               if (cmd == CMD_SUBSCRIBE) begin
                  if (pos < n) begin
                     d.status = STS_DUP_MISS;
                  end else begin
                     d.status = STS_FULL;
                     for (int i = 0; i < n; i++) begin
                        if (subscriber_rows[sig][i] == 8'h00) begin
                           subscriber_rows[sig][i] = id;
                           d.status = STS_OK;
                           break;
                        end
                     end
                  end
               end else if (pos == n) begin
                  d.status = STS_DUP_MISS;
               end else begin
                  // later slots close the gap so the row stays compact
                  for (int i = pos; i < n - 1; i++)
                     subscriber_rows[sig][i] = subscriber_rows[sig][i + 1];
                  subscriber_rows[sig][n - 1] = 8'h00;
               end
               pending_deliveries.push_back(d);
            end
            default: begin
               total = 0;
               for (int i = 0; i < n; i++) begin
                  if (subscriber_rows[sig][i] != 8'h00) total++;
               end
               if (cmd == CMD_COUNT || total == 0) begin
                  d.count = (cmd == CMD_COUNT) ? 4'(total) : 4'd0;
                  pending_deliveries.push_back(d);
               end else begin
                  k = 0;
                  for (int i = 0; i < n; i++) begin
                     if (subscriber_rows[sig][i] != 8'h00) begin
                        k++;
                        d.has_subscriber = 1'b1;
                        d.subscriber_out = subscriber_rows[sig][i];
                        d.count = 4'(total);
                        d.last = (k == total);
                        pending_deliveries.push_back(d);
                     end
                  end
               end
            end
         endcase
      endfunction

      function void check_result(logic [1:0] status, logic has, logic [7:0] sub_id,
                                 logic [3:0] count, logic last);
         delivery_type want;
         checked++;
         if (pending_deliveries.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected delivery: status %0d has %0d id %0h count %0d last %0d",
                        status, has, sub_id, count, last);
            return;
         end
         want = pending_deliveries.pop_front();
         if (status !== want.status || has !== want.has_subscriber ||
             sub_id !== want.subscriber_out || count !== want.count || last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("delivery %0d: expected %s/%0d/%0h/%0d/%0d, got %0d/%0d/%0h/%0d/%0d",
                        checked, want.status.name(), want.has_subscriber, want.subscriber_out,
                        want.count, want.last, status, has, sub_id, count, last);
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [1:0] req_cmd;
   logic [4:0] req_signal;
   logic [7:0] req_subscriber_id;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [1:0] rsp_status;
   logic       rsp_has_subscriber;
   logic [7:0] rsp_subscriber_out;
   logic [3:0] rsp_count;
   logic       rsp_last;
   logic       csr_wr_en;
   logic [1:0] csr_index;
   logic [5:0] csr_wdata;

   subscription_tracker_type tracker = new();
   bit send_burst = 1'b0;
   bit recv_burst = 1'b0;
   bit hold_off_pending = 1'b0;
   int requests_sent = 0;
   int settings_used = 1;

   event_subscription_table_unit u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_signal(req_signal),
      .req_subscriber_id(req_subscriber_id),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_has_subscriber(rsp_has_subscriber),
      .rsp_subscriber_out(rsp_subscriber_out),
      .rsp_count(rsp_count),
      .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task send_request(cmd_type cmd, logic [4:0] sig, logic [7:0] id);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_signal <= sig;
      req_subscriber_id <= id;
      do @(posedge clock); while (req_stall !== 1'b0);
      tracker.note_request(cmd, sig, id);
      requests_sent++;
   endtask

   task run_random(int items);
      int lo;
      int hi;
      int pick;
      int sig;
      int id;
      cmd_type cmd;
      for (int k = 0; k < items; k++) begin
         if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
         pick = $urandom_range(0, 99);
         cmd = (pick < 40) ? CMD_SUBSCRIBE : (pick < 65) ? CMD_UNSUBSCRIBE :
               (pick < 75) ? CMD_COUNT : CMD_PUBLISH;
         lo = tracker.first_user;
         hi = ((tracker.signals_used > 32) ? 32 : tracker.signals_used) - 1;
         // keep most traffic on a few legal rows so they fill up and empty again
         if (lo <= hi && $urandom_range(0, 99) < 85)
            sig = lo + $urandom_range(0, (hi - lo < 3) ? hi - lo : 3);
         else
            sig = $urandom_range(0, 31);
         pick = $urandom_range(0, 99);
         if (pick < 80) id = $urandom_range(1, 10);
         else if (pick < 85) id = 0;
         else id = $urandom_range(0, 255);
         send_request(cmd, 5'(sig), 8'(id));
      end
   endtask

   task write_csr(logic [1:0] idx, logic [5:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      tracker.write_reg(idx, value);
   endtask

   // only while idle: no request offered and every delivery so far has been taken
   task apply_setting(logic [5:0] first, logic [5:0] signals, logic [5:0] slots);
      req_valid <= 1'b0;
      while (tracker.pending_deliveries.size() != 0) @(posedge clock);
      write_csr(CSR_FIRST_USER, first);
      write_csr(CSR_SIGNALS_USED, signals);
      write_csr(CSR_SLOTS_USED, slots);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   initial begin : drain
      int wait_cycles;
      rsp_stall = 1'b0;
      forever begin
         if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
         wait_cycles = recv_burst ? 0 : $urandom_range(0, 12);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            wait_cycles += HOLD_OFF_CYCLES;
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         tracker.check_result(rsp_status, rsp_has_subscriber, rsp_subscriber_out,
                              rsp_count, rsp_last);
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_SUBSCRIBE;
      req_signal = 5'd0;
      req_subscriber_id = 8'h00;
      csr_wr_en = 1'b0;
      csr_index = CSR_FIRST_USER;
      csr_wdata = 6'd0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // register values after reset
      send_request(CMD_SUBSCRIBE, 5'd4, 8'h01);
      send_request(CMD_SUBSCRIBE, 5'd4, 8'hff);
      send_request(CMD_SUBSCRIBE, 5'd4, 8'h01);
      send_request(CMD_SUBSCRIBE, 5'd4, 8'h00);
      send_request(CMD_SUBSCRIBE, 5'd3, 8'h07);
      send_request(CMD_SUBSCRIBE, 5'd31, 8'h80);
      send_request(CMD_COUNT, 5'd0, 8'h00);
      send_request(CMD_PUBLISH, 5'd4, 8'h00);
      send_request(CMD_PUBLISH, 5'd5, 8'h2a);
      send_request(CMD_PUBLISH, 5'd2, 8'h00);
      // ninth subscribe finds the row full
      for (int k = 0; k < 9; k++) send_request(CMD_SUBSCRIBE, 5'd6, 8'(8'h10 + k));
      send_request(CMD_PUBLISH, 5'd6, 8'h00);
      send_request(CMD_UNSUBSCRIBE, 5'd6, 8'h13);
      send_request(CMD_UNSUBSCRIBE, 5'd6, 8'h13);
      send_request(CMD_UNSUBSCRIBE, 5'd6, 8'h00);
      send_request(CMD_UNSUBSCRIBE, 5'd1, 8'h05);
      send_request(CMD_COUNT, 5'd6, 8'h00);
      send_request(CMD_PUBLISH, 5'd6, 8'h00);

      // one long hold-off on the response side while requests keep coming
      hold_off_pending = 1'b1;
      run_random(40);
      apply_setting(6'd0, 6'd63, 6'd3);
      run_random(25);
      apply_setting(6'd31, 6'd33, 6'd0);
      run_random(15);
      apply_setting(6'd2, 6'd20, 6'd15);
      run_random(25);
      apply_setting(6'd1, 6'd1, 6'd8);
      run_random(10);
      apply_setting(6'd0, 6'd0, 6'd1);
      run_random(5);
      apply_setting(6'd4, 6'd32, 6'd5);
      run_random(30);
      req_valid <= 1'b0;

      while (tracker.pending_deliveries.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);

      $display("%0d requests under %0d register settings, %0d deliveries checked",
               requests_sent, settings_used, tracker.checked);
      $display("%0d mismatches, %0d deliveries never arrived, one %0d-cycle response hold-off",
               tracker.mismatches, tracker.pending_deliveries.size(), HOLD_OFF_CYCLES);
      if (tracker.mismatches == 0 && tracker.pending_deliveries.size() == 0) begin
         $display("event_subscription_table_unit: match");
      end else begin
         $display("event_subscription_table_unit: mismatch");
      end
      $finish;
   end

   initial begin
      #(12 * 400000);
      $display("run timed out");
      $display("event_subscription_table_unit: mismatch");
      $finish;
   end

endmodule
